@@ hdl/spag_pkg.sv @@
// Package for the spiral placement address generator.
// Holds the shared widths, register indexes, FSM and heading encodings and the
// structs between the controller, the datapath and the configuration block.
package spag_pkg;

    // Fixed field widths.
    localparam int DIM_W   = 12;
    localparam int CNT_W   = 24;
    localparam int COLOR_W = 24;
    localparam int COORD_W = 11;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK
    } t_state;

    // Spiral leg direction, in walking order.
    typedef enum logic [1:0] {
        HEAD_RIGHT,
        HEAD_DOWN,
        HEAD_LEFT,
        HEAD_UP
    } t_heading;

    // Effective frame settings.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [CNT_W-1:0] total;
    } t_frame_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic centre;
        logic step;
        logic emit_fail;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic first;
        logic exhausted;
        logic can_move;
        logic hit;
        logic out_free;
    } t_dp_status;

endpackage

@@ hdl/spiral_placement_address_gen.sv @@
// Top level of the spiral placement address generator.
// Instantiates spag_cfg, spag_ctrl and spag_dp; depends on spag_pkg.
//
// Each accepted pixel color is given the next in-frame coordinate of a square
// spiral that starts at the frame center (width/2, height/2) and runs its legs
// right, down, left, up with lengths 0, 0, 1, 1, 2, 2 and so on. One item is
// in work at a time: the input transfer is followed by the placement check,
// and then the walk makes one spiral move or turn per cycle until it reaches
// an in-frame position; the first placement and a full frame need no walk
// (about one move per placement on a square frame, more on a narrow one
// where out-of-frame positions are passed over). A spiral that runs out
// reports the overflow from the walk. The result sits in an output
// register, so the next item is accepted while it waits; the check and the
// walk stall only when a second result is ready before the first is taken.
// After width*height placements, or once the spiral has passed every
// possible frame position, results carry the overflow flag with column and
// row zero.
module spiral_placement_address_gen
    import spag_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] pixel_color
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [10:0] col, [21:11] row, [45:22] color_out, [47:46] zero
    output logic        m_tuser    // [0] overflow
);

    t_frame_cfg         frame_cfg;
    t_dp_cmd            dp_cmd;
    t_dp_status         dp_status;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic [COLOR_W-1:0] out_color;

    spag_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (frame_cfg)
    );

    spag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    spag_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (frame_cfg),
        .i_cmd      (dp_cmd),
        .o_status   (dp_status),
        .i_color    (s_tdata),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_col      (out_col),
        .o_row      (out_row),
        .o_color    (out_color),
        .o_overflow (m_tuser)
    );

    // Pack the result fields, first field lowest.
    assign m_tdata = {2'b00, out_color, out_row, out_col};

endmodule

@@ hdl/spag_cfg.sv @@
// Configuration registers of the spiral placement address generator.
// Implements the APB-style write and read port; depends on spag_pkg.
// Produces the saturated frame dimensions and the registered pixel total.
module spag_cfg
    import spag_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_frame_cfg       o_cfg
);

    localparam logic [DIM_W-1:0] RESET_DIM = 12'd64;

    // Saturate a dimension at MAX_DIM.
    function automatic logic [DIM_W-1:0] f_eff(input logic [DIM_W-1:0] v);
        f_eff = ({4'b0, v} > 16'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [CNT_W-1:0] r_total;
    logic [DIM_W-1:0] n_width;
    logic [DIM_W-1:0] n_height;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Next register values on a write transfer.
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (wr_en) begin
            if (paddr[2] == REG_WIDTH) begin
                n_width = pwdata[DIM_W-1:0];
            end else begin
                n_height = pwdata[DIM_W-1:0];
            end
        end
    end

    // Registers; the total is formed from the next dimensions, so it changes
    // at the same edge as they do.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_DIM;
            r_height <= RESET_DIM;
            r_total  <= f_eff(RESET_DIM) * f_eff(RESET_DIM);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_total  <= f_eff(n_width) * f_eff(n_height);
        end
    end

    // Read back the raw register value.
    assign prdata = (paddr[2] == REG_WIDTH) ? {20'b0, r_width} : {20'b0, r_height};

    assign o_cfg.width  = f_eff(r_width);
    assign o_cfg.height = f_eff(r_height);
    assign o_cfg.total  = r_total;

endmodule

@@ hdl/spag_dp.sv @@
// Datapath of the spiral placement address generator.
// Holds the walk position, leg counters, placement count and output register;
// depends on spag_pkg and is driven by spag_ctrl commands.
module spag_dp
    import spag_pkg::*;
#(
    parameter int MAX_DIM = 2048
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_frame_cfg         i_cfg,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [COLOR_W-1:0] i_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_col,
    output logic [COORD_W-1:0] o_row,
    output logic [COLOR_W-1:0] o_color,
    output logic               o_overflow
);

    localparam int LEN_W = $clog2(2 * MAX_DIM + 4);
    localparam int POS_W = (LEN_W + 2 > 13) ? LEN_W + 2 : 13;
    localparam logic [LEN_W-1:0] SPIRAL_LIMIT = LEN_W'(2 * MAX_DIM + 2);

    logic signed [POS_W-1:0] r_x;
    logic signed [POS_W-1:0] r_y;
    t_heading                r_head;
    logic [LEN_W-1:0]        r_len;
    logic [LEN_W-1:0]        r_prog;
    logic [CNT_W-1:0]        r_placed;
    logic [COLOR_W-1:0]      r_color;
    logic                    r_out_valid;
    logic [COORD_W-1:0]      r_col;
    logic [COORD_W-1:0]      r_row;
    logic [COLOR_W-1:0]      r_out_color;
    logic                    r_ovf;

    logic signed [POS_W-1:0] n_x;
    logic signed [POS_W-1:0] n_y;
    logic signed [POS_W-1:0] centre_x;
    logic signed [POS_W-1:0] centre_y;
    logic [POS_W-1:0]        w_ext;
    logic [POS_W-1:0]        h_ext;
    logic                    can_move;
    logic                    hit;
    logic                    step_hit;
    logic                    load;
    logic                    out_free;

    assign w_ext    = {{(POS_W-DIM_W){1'b0}}, i_cfg.width};
    assign h_ext    = {{(POS_W-DIM_W){1'b0}}, i_cfg.height};
    assign centre_x = {{(POS_W-DIM_W+1){1'b0}}, i_cfg.width[DIM_W-1:1]};
    assign centre_y = {{(POS_W-DIM_W+1){1'b0}}, i_cfg.height[DIM_W-1:1]};

    // Position after one move along the current heading.
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        case (r_head)
            HEAD_RIGHT: n_x = r_x + POS_W'(1);
            HEAD_DOWN:  n_y = r_y + POS_W'(1);
            HEAD_LEFT:  n_x = r_x - POS_W'(1);
            HEAD_UP:    n_y = r_y - POS_W'(1);
            default:    n_x = r_x;
        endcase
    end

    // Frame bounds check of the next position.
    assign can_move = (r_prog < r_len);
    assign hit      = !n_x[POS_W-1] && !n_y[POS_W-1] &&
                      (unsigned'(n_x) < w_ext) && (unsigned'(n_y) < h_ext);
    assign step_hit = i_cmd.step && can_move && hit;
    assign out_free = !r_out_valid || i_ready;
    assign load     = i_cmd.centre || i_cmd.emit_fail || step_hit;

    // Walk state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_head   <= HEAD_RIGHT;
            r_len    <= '0;
            r_prog   <= '0;
            r_placed <= '0;
        end else begin
            if (i_cmd.centre) begin
                r_x      <= centre_x;
                r_y      <= centre_y;
                r_placed <= r_placed + CNT_W'(1);
            end else if (i_cmd.step) begin
                if (can_move) begin
                    r_x    <= n_x;
                    r_y    <= n_y;
                    r_prog <= r_prog + LEN_W'(1);
                    if (hit) begin
                        r_placed <= r_placed + CNT_W'(1);
                    end
                end else begin
                    if (r_head == HEAD_DOWN || r_head == HEAD_UP) begin
                        r_len <= r_len + LEN_W'(1);
                    end
                    r_head <= t_heading'(r_head + 2'd1);
                    r_prog <= '0;
                end
            end
        end
    end

    // Captured input color.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_color <= i_color;
        end
    end

    // Output register: loaded with a result, cleared when the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_color <= r_color;
            r_ovf       <= i_cmd.emit_fail;
            if (i_cmd.centre) begin
                r_col <= centre_x[COORD_W-1:0];
                r_row <= centre_y[COORD_W-1:0];
            end else if (i_cmd.emit_fail) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_x[COORD_W-1:0];
                r_row <= n_y[COORD_W-1:0];
            end
        end
    end

    assign o_status.full      = (r_placed >= i_cfg.total);
    assign o_status.first     = (r_placed == '0);
    assign o_status.exhausted = (r_len > SPIRAL_LIMIT);
    assign o_status.can_move  = can_move;
    assign o_status.hit       = hit;
    assign o_status.out_free  = out_free;

    assign o_valid    = r_out_valid;
    assign o_col      = r_col;
    assign o_row      = r_row;
    assign o_color    = r_out_color;
    assign o_overflow = r_ovf;

    // The leg progress never runs past the leg length.
    a_prog_in_leg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prog <= r_len)
        else $error("leg progress beyond leg length");

    // A placed result always lies inside the frame.
    a_result_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ovf) |-> ({1'b0, r_col} < i_cfg.width &&
                                     {1'b0, r_row} < i_cfg.height))
        else $error("placed coordinate outside the frame");

endmodule

@@ hdl/spag_ctrl.sv @@
// Controller of the spiral placement address generator.
// Sequences acceptance, the first-placement and full checks and the spiral
// walk one step per cycle, stalling while a result finds the output full; depends on spag_pkg.
module spag_ctrl
    import spag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                if (i_status.full || i_status.first) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_fail = i_status.full;
                        o_cmd.centre    = !i_status.full;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.exhausted) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_fail = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else if (i_status.can_move && i_status.hit) begin
                    if (i_status.out_free) begin
                        o_cmd.step = 1'b1;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // At most one walk-changing command in a cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.centre, o_cmd.step, o_cmd.emit_fail}))
        else $error("conflicting datapath commands");

    // A result is only issued when the output register can take it.
    a_result_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.centre || o_cmd.emit_fail ||
         (o_cmd.step && i_status.can_move && i_status.hit)) |-> i_status.out_free)
        else $error("result issued into a full output register");

endmodule
